FILE: src/coupp_pkg.sv
// ----------------------------------------------------------------------------
// coupp_pkg
// shared types and constants of the can-over-udp packet parser
// ----------------------------------------------------------------------------
`default_nettype none

package coupp_pkg;

  // data byte limit of one frame
  localparam int MAX_DATA_BYTES = 64;

  // id bytes of a frame header before the length byte
  localparam int ID_BYTES = 4;

  // frame id flag and length byte flag
  localparam int RTR_BIT = 30;
  localparam int FD_BIT  = 7;

  // opcode of a data packet
  localparam logic [7:0] OPCODE_DATA = 8'd0;

  // result kinds
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_FRAME  = 2'd1;
  localparam logic [1:0] KIND_PACKET = 2'd2;

  // packet status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_VER    = 3'd1;
  localparam logic [2:0] ST_BAD_OPCODE = 3'd2;
  localparam logic [2:0] ST_TRUNC_HDR  = 3'd3;
  localparam logic [2:0] ST_TRUNC_DATA = 3'd4;
  localparam logic [2:0] ST_LEN_LIMIT  = 3'd5;

  // all results caused by one accepted byte
  typedef struct packed {
    logic        has_data;
    logic        has_frame;
    logic        has_pkt;
    logic [31:0] can_id;
    logic [7:0]  len;
    logic [7:0]  flags;
    logic [7:0]  data;
    logic [5:0]  idx;
    logic        frame_ok;
    logic [2:0]  status;
    logic [15:0] cnt_old;
    logic [15:0] cnt_new;
    logic [7:0]  seq;
  } qentry_t;

endpackage

`default_nettype wire

FILE: src/can_over_udp_packet_parser_unit.sv
// ----------------------------------------------------------------------------
// can_over_udp_packet_parser_unit
// decodes CAN frames carried in a UDP datagram, one payload byte at a time
// ----------------------------------------------------------------------------
// Input channel: byte_valid / byte_stall with in_byte and end_of_datagram; a
// transaction is one datagram byte, end_of_datagram set on the last one.
// Output channel: result_valid / result_stall with one result per transaction:
// a data byte, a frame done (frame_ok) or a packet done (status).
// Config: version_we / version_wdata writes the expected version (reset 2).
// A byte's results go through the queue and then the output register. The
// parser takes one byte per cycle while byte_stall is low; the emitter sends
// one result per cycle unless stalled, so a byte with up to three results
// holds it until all are sent. Bytes that cause no result pass without using
// the emitter. Between the two sits a queue of QUEUE_DEPTH byte bundles;
// byte_stall rises when it is full. When result_stall is high the output
// register holds, the queue fills, and then the input stalls. Reset clears the
// parser to the packet header, empties the queue and drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module can_over_udp_packet_parser_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        version_we,
  input  wire logic [7:0]  version_wdata,
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        end_of_datagram,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [1:0]       kind,
  output logic [31:0]      can_id,
  output logic [7:0]       frame_len,
  output logic [7:0]       fd_flags,
  output logic [7:0]       data_byte,
  output logic [5:0]       byte_index,
  output logic             frame_ok,
  output logic [2:0]       status,
  output logic [15:0]      frames_delivered,
  output logic [7:0]       sequence_res,
  output logic             last_of_run
);

  coupp_pkg::qentry_t q_wdata, q_head;
  logic q_push, q_pop, q_empty, q_full;

  // parser
  coupp_front u_front (
    .clk             (clk),
    .rst             (rst),
    .version_we      (version_we),
    .version_wdata   (version_wdata),
    .byte_valid      (byte_valid),
    .in_byte         (in_byte),
    .end_of_datagram (end_of_datagram),
    .q_full          (q_full),
    .byte_stall      (byte_stall),
    .push            (q_push),
    .entry           (q_wdata)
  );

  // bundle queue
  coupp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .head  (q_head),
    .empty (q_empty),
    .full  (q_full)
  );

  // emitter
  coupp_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (q_head),
    .empty            (q_empty),
    .pop              (q_pop),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .kind             (kind),
    .can_id           (can_id),
    .frame_len        (frame_len),
    .fd_flags         (fd_flags),
    .data_byte        (data_byte),
    .byte_index       (byte_index),
    .frame_ok         (frame_ok),
    .status           (status),
    .frames_delivered (frames_delivered),
    .sequence_res     (sequence_res),
    .last_of_run      (last_of_run)
  );

endmodule

`default_nettype wire

FILE: src/coupp_front.sv
// ----------------------------------------------------------------------------
// coupp_front
// byte parser: walks packet and frame headers, builds one queue entry per result-bearing byte
// ----------------------------------------------------------------------------
`default_nettype none

module coupp_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              version_we,
  input  wire logic [7:0]        version_wdata,
  input  wire logic              byte_valid,
  input  wire logic [7:0]        in_byte,
  input  wire logic              end_of_datagram,
  input  wire logic              q_full,
  output logic                   byte_stall,
  output logic                   push,
  output coupp_pkg::qentry_t     entry
);

  typedef enum logic [4:0] {
    PH_PKT = 5'b00001,
    PH_FRM = 5'b00010,
    PH_FLG = 5'b00100,
    PH_DAT = 5'b01000,
    PH_SKP = 5'b10000
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  expected_version;
  logic [2:0]  fbc, fbc_next;
  logic [15:0] frames_remaining, frames_remaining_next;
  logic [31:0] id_shift, id_shift_next;
  logic [7:0]  length_byte, length_byte_next;
  logic [7:0]  flags_byte, flags_byte_next;
  logic [6:0]  data_position, data_position_next;
  logic [7:0]  sequence_held, sequence_held_next;
  logic [15:0] ok_frame_count, ok_frame_count_next;

  logic        accept;
  logic        bd_go, fd_go, ff_go, end_go;
  logic [2:0]  ff_status, end_status;
  logic [6:0]  dl;
  logic        eod;
  logic [7:0]  b;

  assign byte_stall = q_full;
  assign accept     = byte_valid && !byte_stall;
  assign eod        = end_of_datagram;
  assign b          = in_byte;

  // next state and the results of this byte
  always_comb begin
    phase_next            = phase;
    fbc_next              = fbc;
    frames_remaining_next = frames_remaining;
    id_shift_next         = id_shift;
    length_byte_next      = length_byte;
    flags_byte_next       = flags_byte;
    data_position_next    = data_position;
    sequence_held_next    = sequence_held;
    ok_frame_count_next   = ok_frame_count;
    bd_go      = 1'b0;
    fd_go      = 1'b0;
    ff_go      = 1'b0;
    end_go     = 1'b0;
    ff_status  = coupp_pkg::ST_OK;
    end_status = coupp_pkg::ST_OK;
    dl         = 7'd0;
    entry      = '0;

    unique case (phase)
      PH_PKT: begin
        case (fbc)
          3'd0: begin
            ok_frame_count_next   = 16'd0;
            sequence_held_next    = 8'd0;
            frames_remaining_next = 16'd0;
            if (b != expected_version) begin
              end_go = 1'b1; end_status = coupp_pkg::ST_BAD_VER;
            end else if (eod) begin
              end_go = 1'b1; end_status = coupp_pkg::ST_TRUNC_HDR;
            end else begin
              fbc_next = 3'd1;
            end
          end
          3'd1: begin
            if (b != coupp_pkg::OPCODE_DATA) begin
              end_go = 1'b1; end_status = coupp_pkg::ST_BAD_OPCODE;
            end else if (eod) begin
              end_go = 1'b1; end_status = coupp_pkg::ST_TRUNC_HDR;
            end else begin
              fbc_next = 3'd2;
            end
          end
          3'd2: begin
            sequence_held_next = b;
            if (eod) begin
              end_go = 1'b1; end_status = coupp_pkg::ST_TRUNC_HDR;
            end else begin
              fbc_next = 3'd3;
            end
          end
          3'd3: begin
            frames_remaining_next = {b, 8'd0};
            if (eod) begin
              end_go = 1'b1; end_status = coupp_pkg::ST_TRUNC_HDR;
            end else begin
              fbc_next = 3'd4;
            end
          end
          default: begin
            frames_remaining_next = {frames_remaining[15:8], b};
            if (frames_remaining_next == 16'd0) begin
              end_go = 1'b1; end_status = coupp_pkg::ST_OK;
            end else if (eod) begin
              end_go = 1'b1; end_status = coupp_pkg::ST_TRUNC_HDR;
            end else begin
              phase_next         = PH_FRM;
              fbc_next           = 3'd0;
              id_shift_next      = 32'd0;
              length_byte_next   = 8'd0;
              flags_byte_next    = 8'd0;
              data_position_next = 7'd0;
            end
          end
        endcase
      end
      PH_FRM: begin
        if (fbc < 3'(coupp_pkg::ID_BYTES)) begin
          id_shift_next = {id_shift[23:0], b};
          fbc_next      = fbc + 3'd1;
          if (eod) begin
            end_go = 1'b1; end_status = coupp_pkg::ST_TRUNC_HDR;
          end
        end else begin
          length_byte_next = b;
          if (b[coupp_pkg::FD_BIT]) begin
            if (eod) begin
              end_go = 1'b1; end_status = coupp_pkg::ST_TRUNC_HDR;
            end else begin
              phase_next = PH_FLG;
            end
          end else begin
            bd_go = 1'b1;
          end
        end
      end
      PH_FLG: begin
        flags_byte_next = b;
        bd_go           = 1'b1;
      end
      PH_DAT: begin
        entry.has_data     = 1'b1;
        data_position_next = data_position + 7'd1;
        if (data_position_next >= length_byte[6:0]) begin
          fd_go = 1'b1;
        end else if (eod) begin
          ff_go = 1'b1; ff_status = coupp_pkg::ST_TRUNC_DATA;
        end
      end
      PH_SKP: begin
        if (eod) begin
          phase_next = PH_PKT;
          fbc_next   = 3'd0;
        end
      end
      default: begin
        phase_next = PH_PKT;
        fbc_next   = 3'd0;
      end
    endcase

    // frame header complete: decide how the data part goes
    if (bd_go) begin
      dl = length_byte_next[6:0];
      if (id_shift[coupp_pkg::RTR_BIT]) begin
        fd_go = 1'b1;
      end else if (dl > 7'(coupp_pkg::MAX_DATA_BYTES)) begin
        ff_go = 1'b1; ff_status = coupp_pkg::ST_LEN_LIMIT;
      end else if (dl == 7'd0) begin
        fd_go = 1'b1;
      end else if (eod) begin
        ff_go = 1'b1; ff_status = coupp_pkg::ST_TRUNC_DATA;
      end else begin
        phase_next         = PH_DAT;
        data_position_next = 7'd0;
      end
    end

    // frame fields as they stand when a frame result is taken
    entry.can_id  = id_shift;
    entry.len     = length_byte_next;
    entry.flags   = flags_byte_next;
    entry.data    = b;
    entry.idx     = data_position[5:0];
    entry.cnt_old = ok_frame_count;

    // frame complete
    if (fd_go) begin
      ok_frame_count_next   = ok_frame_count + 16'd1;
      frames_remaining_next = frames_remaining - 16'd1;
      entry.has_frame       = 1'b1;
      entry.frame_ok        = 1'b1;
      if (frames_remaining_next == 16'd0) begin
        end_go = 1'b1; end_status = coupp_pkg::ST_OK;
      end else if (eod) begin
        end_go = 1'b1; end_status = coupp_pkg::ST_TRUNC_HDR;
      end else begin
        phase_next         = PH_FRM;
        fbc_next           = 3'd0;
        id_shift_next      = 32'd0;
        length_byte_next   = 8'd0;
        flags_byte_next    = 8'd0;
        data_position_next = 7'd0;
      end
    end

    // frame dropped
    if (ff_go) begin
      entry.has_frame = 1'b1;
      entry.frame_ok  = 1'b0;
      end_go          = 1'b1;
      end_status      = ff_status;
    end

    // packet ends here
    if (end_go) begin
      entry.has_pkt = 1'b1;
      entry.status  = end_status;
      phase_next    = eod ? PH_PKT : PH_SKP;
      fbc_next      = 3'd0;
    end

    entry.cnt_new = ok_frame_count_next;
    entry.seq     = sequence_held_next;
  end

  assign push = accept && (entry.has_data || entry.has_frame || entry.has_pkt);

  // version register
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= 8'd2;
    end else if (version_we) begin
      expected_version <= version_wdata;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_PKT;
      fbc              <= 3'd0;
      frames_remaining <= 16'd0;
      id_shift         <= 32'd0;
      length_byte      <= 8'd0;
      flags_byte       <= 8'd0;
      data_position    <= 7'd0;
      sequence_held    <= 8'd0;
      ok_frame_count   <= 16'd0;
    end else if (accept) begin
      phase            <= phase_next;
      fbc              <= fbc_next;
      frames_remaining <= frames_remaining_next;
      id_shift         <= id_shift_next;
      length_byte      <= length_byte_next;
      flags_byte       <= flags_byte_next;
      data_position    <= data_position_next;
      sequence_held    <= sequence_held_next;
      ok_frame_count   <= ok_frame_count_next;
    end
  end

  // data position stays inside the frame payload
  a_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DAT |-> data_position < length_byte[6:0])
    else $error("data position past frame length");

  a_pos_limit: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DAT |-> data_position < 7'(coupp_pkg::MAX_DATA_BYTES))
    else $error("data position past payload limit");

endmodule

`default_nettype wire

FILE: src/coupp_queue.sv
// ----------------------------------------------------------------------------
// coupp_queue
// short fifo of per-byte result bundles between parser and emitter
// ----------------------------------------------------------------------------
`default_nettype none

module coupp_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire coupp_pkg::qentry_t wdata,
  input  wire logic               pop,
  output coupp_pkg::qentry_t      head,
  output logic                    empty,
  output logic                    full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  coupp_pkg::qentry_t mem [DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;

  assign empty = (count == CW'(0));
  assign full  = (count == CW'(DEPTH));
  assign head  = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue push while full");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

FILE: src/coupp_back.sv
// ----------------------------------------------------------------------------
// coupp_back
// emitter: unpacks each bundle into its results, one per cycle unless stalled, into a register
// ----------------------------------------------------------------------------
`default_nettype none

module coupp_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire coupp_pkg::qentry_t head,
  input  wire logic               empty,
  output logic                    pop,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic [1:0]              kind,
  output logic [31:0]             can_id,
  output logic [7:0]              frame_len,
  output logic [7:0]              fd_flags,
  output logic [7:0]              data_byte,
  output logic [5:0]              byte_index,
  output logic                    frame_ok,
  output logic [2:0]              status,
  output logic [15:0]             frames_delivered,
  output logic [7:0]              sequence_res,
  output logic                    last_of_run
);

  logic       data_sent, frame_sent;
  logic [2:0] pend, pick;
  logic       load, last;

  // results of the head bundle still to send: packet, frame, data
  assign pend = {head.has_pkt, head.has_frame && !frame_sent, head.has_data && !data_sent};
  assign pick = pend & (~pend + 3'd1);
  assign last = ((pend & ~pick) == 3'd0);
  assign load = !empty && (!result_valid || !result_stall);
  assign pop  = load && last;

  // progress through the head bundle
  always_ff @(posedge clk) begin
    if (rst) begin
      data_sent  <= 1'b0;
      frame_sent <= 1'b0;
    end else if (load) begin
      if (last) begin
        data_sent  <= 1'b0;
        frame_sent <= 1'b0;
      end else begin
        data_sent  <= data_sent || pick[0];
        frame_sent <= frame_sent || pick[1];
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      sequence_res <= head.seq;
      last_of_run  <= last;
      if (pick[0]) begin
        kind             <= coupp_pkg::KIND_DATA;
        can_id           <= head.can_id;
        frame_len        <= head.len;
        fd_flags         <= head.flags;
        data_byte        <= head.data;
        byte_index       <= head.idx;
        frame_ok         <= 1'b0;
        status           <= coupp_pkg::ST_OK;
        frames_delivered <= head.cnt_old;
      end else if (pick[1]) begin
        kind             <= coupp_pkg::KIND_FRAME;
        can_id           <= head.can_id;
        frame_len        <= head.frame_ok ? head.len : 8'd0;
        fd_flags         <= head.flags;
        data_byte        <= 8'd0;
        byte_index       <= 6'd0;
        frame_ok         <= head.frame_ok;
        status           <= coupp_pkg::ST_OK;
        frames_delivered <= head.cnt_new;
      end else begin
        kind             <= coupp_pkg::KIND_PACKET;
        can_id           <= 32'd0;
        frame_len        <= 8'd0;
        fd_flags         <= 8'd0;
        data_byte        <= 8'd0;
        byte_index       <= 6'd0;
        frame_ok         <= 1'b0;
        status           <= head.status;
        frames_delivered <= head.cnt_new;
      end
    end
  end

  a_pick_one: assert property (@(posedge clk) disable iff (rst)
    load |-> $onehot(pick))
    else $error("emitter loaded with nothing pending");

  a_frame_ok_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind != coupp_pkg::KIND_FRAME |-> !frame_ok)
    else $error("frame_ok set outside a frame result");

endmodule

`default_nettype wire
